[hdl/deq_pkg.sv]
// Shared types and constants for the double-ended queue core.
// No dependencies; compiled first.
package deq_pkg;

   localparam int DATA_W = 32;
   localparam int FUNC_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_DUMP       = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DUMP
   } state_type;

endpackage

[hdl/deq_if.sv]
// Valid/ready channel interfaces for request and response transactions.
// Depends on deq_pkg.
interface deq_req_if import deq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   status_type               status;
   logic                     last;

   modport source (output valid, output data, output status, output last, input ready);
   modport sink   (input valid, input data, input status, input last, output ready);
endinterface

[hdl/deq_ring_mem.sv]
// Ring store: one write port, one read port, registered read data.
// Depends on deq_pkg.
module deq_ring_mem import deq_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] ring_mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/double_ended_queue_with_dump_core.sv]
// Double-ended queue core over a ring store; depends on deq_pkg, deq_if, deq_ring_mem.
// Push and every empty/full result go straight to the response register, 1 transaction/cycle while it is free.
// Pop: memory read, then ST_POP loads the response register; next request taken after the response loads.
// Dump of N entries: one entry per cycle while the response slot is free, out of the single read port.
// Synchronous active-high reset empties the queue (front and count to zero);
// the ring memory itself is not cleared.
module double_ended_queue_with_dump_core import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_bus,
   deq_rsp_if.source  rsp_bus
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

   // wrap-around index steps (DEPTH need not be a power of two)
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_LAST : i - IDX_W'(1);
   endfunction

   // ---------------- state ----------------
   state_type                state_ff,     state_in;
   logic [IDX_W-1:0]         front_ff,     front_in;
   logic [CNT_W-1:0]         count_ff,     count_in;
   logic [IDX_W-1:0]         dump_pos_ff,  dump_pos_in;   // next entry to read
   logic [CNT_W-1:0]         dump_left_ff, dump_left_in;  // entries not yet sent

   // response register
   logic                     out_valid_ff,  out_valid_in;
   logic signed [DATA_W-1:0] out_data_ff,   out_data_in;
   status_type               out_status_ff, out_status_in;
   logic                     out_last_ff,   out_last_in;

   // memory port
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   // ---------------- derived ----------------
   logic             full;
   logic             empty;
   logic             out_free;
   logic             req_fire;
   logic             is_push;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] front_dec;
   logic [SUM_W-1:0] back_sum;
   logic [IDX_W-1:0] back_pos;   // slot just past the back entry
   logic [IDX_W-1:0] back_last;  // slot of the back entry

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   // response slot is empty or drains this cycle
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign is_push   = (req_bus.func == FUNC_PUSH_FRONT) || (req_bus.func == FUNC_PUSH_BACK);

   assign front_inc = idx_inc(front_ff);
   assign front_dec = idx_dec(front_ff);
   // front + count < 2*DEPTH, so one conditional subtract wraps it
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_pos  = (back_sum >= SUM_DEPTH) ? IDX_W'(back_sum - SUM_DEPTH)
                                              : IDX_W'(back_sum);
   assign back_last = idx_dec(back_pos);

   deq_ring_mem #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_bus.func == FUNC_POP_FRONT || req_bus.func == FUNC_POP_BACK)
                   && !empty) begin
                  state_in = ST_POP;
               end else if (req_bus.func == FUNC_DUMP && !empty) begin
                  state_in = ST_DUMP;
               end
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         ST_DUMP: begin
            if (out_free && dump_left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- datapath and memory control ----------------
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      dump_pos_in   = dump_pos_ff;
      dump_left_in  = dump_left_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      wr_data       = req_bus.value;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.func)
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     out_valid_in = 1'b1;
                     out_data_in  = '0;
                     out_last_in  = 1'b1;
                     if (full) begin
                        out_status_in = STATUS_FULL;
                     end else begin
                        out_status_in = STATUS_OK;
                        wr_en         = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        if (req_bus.func == FUNC_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end else begin
                           wr_addr  = back_pos;
                        end
                     end
                  end
                  FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_DUMP: begin
                     if (empty) begin
                        out_valid_in  = 1'b1;
                        out_data_in   = '0;
                        out_status_in = STATUS_EMPTY;
                        out_last_in   = 1'b1;
                     end else begin
                        rd_en = 1'b1;
                        if (req_bus.func == FUNC_POP_FRONT) begin
                           front_in = front_inc;
                           count_in = count_ff - CNT_W'(1);
                        end else if (req_bus.func == FUNC_POP_BACK) begin
                           rd_addr  = back_last;
                           count_in = count_ff - CNT_W'(1);
                        end else begin
                           dump_pos_in  = front_inc;
                           dump_left_in = count_ff;
                        end
                     end
                  end
                  default: begin
                     // unused code: transaction dropped, no response
                  end
               endcase
            end
         end
         ST_POP: begin
            out_valid_in  = 1'b1;
            out_data_in   = rd_data;
            out_status_in = STATUS_OK;
            out_last_in   = 1'b1;
         end
         ST_DUMP: begin
            // rd_data holds the entry to send; prefetch the next one as it goes
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_data_in   = rd_data;
               out_status_in = STATUS_OK;
               out_last_in   = (dump_left_ff == CNT_W'(1));
               dump_left_in  = dump_left_ff - CNT_W'(1);
               if (dump_left_ff != CNT_W'(1)) begin
                  rd_en       = 1'b1;
                  rd_addr     = dump_pos_ff;
                  dump_pos_in = idx_inc(dump_pos_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         dump_left_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_pos_ff   <= dump_pos_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.data   = out_data_ff;
   assign rsp_bus.status = out_status_ff;
   assign rsp_bus.last   = out_last_ff;

   // ---------------- assertions ----------------
   // pop read completes into an empty response slot
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !out_valid_ff)
      else $error("pop data arrived with response slot occupied");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above depth");

   a_dump_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (dump_left_ff != '0) && (dump_left_ff <= count_ff))
      else $error("dump counter out of range");

   a_full_push_noop: assert property (@(posedge clock) disable iff (reset)
      (req_fire && full && is_push) |=> $stable(count_ff) && $stable(front_ff))
      else $error("push onto full queue changed queue state");

endmodule
